@@ hdl/front_panel_setpoint_editor_unit_assert.svh @@
// Assertion macros shared by the setpoint editor RTL.
`ifndef FRONT_PANEL_SETPOINT_EDITOR_UNIT_ASSERT_SVH
`define FRONT_PANEL_SETPOINT_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPSE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fpse assertion failed");

// Next-cycle implication, disabled during reset.
`define FPSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fpse assertion failed");

`endif

@@ hdl/fpse_pkg.sv @@
// Types, constants and helper functions for the front panel setpoint editor.
package fpse_pkg;

    typedef enum logic [1:0] {
        MODE_MAIN  = 2'd0,
        MODE_GRAPH = 2'd1,
        MODE_RAW   = 2'd2,
        MODE_EDIT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_EDIT_TIMEOUT = 3'd0,
        CFG_VOLTAGE_MAX  = 3'd1,
        CFG_VOLTAGE_MIN  = 3'd2,
        CFG_CURRENT_MAX  = 3'd3,
        CFG_CURRENT_MIN  = 3'd4
    } cfg_index_t;

    localparam int CFG_DATA_W = 11;
    localparam int VOLT_W     = 11;
    localparam int CURR_W     = 9;
    localparam int TIMER_W    = 8;
    localparam int COUNT_W    = 16;
    localparam int DIGIT_W    = 3;
    localparam int WEIGHT_W   = 10;
    localparam int SUM_W      = 28;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;

    localparam int DETENT_DIVISOR = 2;

    localparam logic [DIGIT_W-1:0] DIGIT_LAST      = 3'd6;
    localparam logic [DIGIT_W-1:0] DIGIT_VOLT_LAST = 3'd3;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET   = 8'd75;
    localparam logic [VOLT_W-1:0]  VOLT_MAX_RESET  = 11'd1500;
    localparam logic [VOLT_W-1:0]  VOLT_MIN_RESET  = 11'd1;
    localparam logic [CURR_W-1:0]  CURR_MAX_RESET  = 9'd350;
    localparam logic [CURR_W-1:0]  CURR_MIN_RESET  = 9'd1;
    localparam logic [VOLT_W-1:0]  VOLT_TARGET_RESET = 11'd500;
    localparam logic [CURR_W-1:0]  CURR_TARGET_RESET = 9'd50;

    // Weight of the selected decimal digit in hundredths.
    function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [DIGIT_W-1:0] digit);
        logic [WEIGHT_W-1:0] w;
        unique case (digit)
            3'd0:    w = 10'd1000;
            3'd1:    w = 10'd100;
            3'd2:    w = 10'd10;
            3'd3:    w = 10'd1;
            3'd4:    w = 10'd100;
            3'd5:    w = 10'd10;
            default: w = 10'd1;
        endcase
        return w;
    endfunction

    // Limit to hi first, then raise to lo; lo wins when lo > hi.
    function automatic logic [VOLT_W-1:0] clamp_value(input logic signed [SUM_W-1:0] v,
                                                      input logic [VOLT_W-1:0] hi,
                                                      input logic [VOLT_W-1:0] lo);
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] lo_s;
        hi_s = signed'({{(SUM_W-VOLT_W){1'b0}}, hi});
        lo_s = signed'({{(SUM_W-VOLT_W){1'b0}}, lo});
        r = v;
        if (r > hi_s) r = hi_s;
        if (r < lo_s) r = lo_s;
        return r[VOLT_W-1:0];
    endfunction

endpackage

@@ hdl/front_panel_setpoint_editor_unit.sv @@
// Front panel setpoint editor: mode, digit and setpoint editing per display refresh.
`include "front_panel_setpoint_editor_unit_assert.svh"

// One transfer on the s_ side is one display refresh and yields one transfer on
// the m_ side with the state after that refresh. Each refresh passes through the
// single update stage between the input register and the output register,
// so a new refresh is accepted every cycle while m_tready holds. The state
// registers are loaded from that update stage on each refresh.
// The cfg_ port writes the timeout and clamp limits; write it only while idle.
module front_panel_setpoint_editor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [fpse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] mode_button, [1] commit_button, [17:2] encoder_count, [23:18] zero
    input  logic [fpse_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] display_mode, [4:2] edit_digit, [15:5] voltage_setpoint,
    // [24:16] current_setpoint, [35:25] pending_voltage, [44:36] pending_current,
    // [52:45] idle_count, [55:53] zero
    output logic [fpse_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpse_pkg::*;

    // configuration
    logic [TIMER_W-1:0] edit_timeout_reg;
    logic [VOLT_W-1:0]  voltage_max_reg, voltage_min_reg;
    logic [CURR_W-1:0]  current_max_reg, current_min_reg;

    // input register
    logic                      in_valid_reg, in_valid_next;
    logic                      in_mode_reg, in_commit_reg;
    logic signed [COUNT_W-1:0] in_count_reg;

    // editor state
    mode_t               mode_reg, mode_next, return_mode_reg, return_mode_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic [TIMER_W-1:0]  idle_reg, idle_next;
    logic [VOLT_W-1:0]   volt_target_reg, volt_target_next;
    logic [CURR_W-1:0]   curr_target_reg, curr_target_next;
    logic [VOLT_W-1:0]   volt_pend_reg, volt_pend_next;
    logic [CURR_W-1:0]   curr_pend_reg, curr_pend_next;
    logic [COUNT_W-1:0]  last_count_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic  s_fire, proc_fire;
    mode_t mode_btn, mode_cmt;
    logic  timeout_hit;

    logic signed [COUNT_W-1:0]  delta;
    logic signed [COUNT_W-1:0]  steps;
    logic signed [SUM_W-1:0]    change;
    logic signed [SUM_W-1:0]    sum;
    logic [WEIGHT_W-1:0]        weight;
    logic [VOLT_W-1:0]          clamp_hi, clamp_lo, base, clamped;
    logic [TIMER_W-1:0]         idle_inc;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // mode after the two buttons
    always_comb begin
        mode_btn = mode_reg;
        if (in_mode_reg) begin
            unique case (mode_reg)
                MODE_MAIN:  mode_btn = MODE_GRAPH;
                MODE_GRAPH: mode_btn = MODE_RAW;
                MODE_RAW:   mode_btn = MODE_MAIN;
                MODE_EDIT:  mode_btn = MODE_EDIT;
            endcase
        end
        mode_cmt         = mode_btn;
        return_mode_next = return_mode_reg;
        if (in_commit_reg) begin
            if (mode_btn == MODE_EDIT) begin
                if (return_mode_reg != MODE_EDIT) mode_cmt = return_mode_reg;
            end else begin
                return_mode_next = mode_btn;
                mode_cmt         = MODE_EDIT;
            end
        end
    end

    // next state of the display mode
    always_comb begin
        mode_next = mode_cmt;
        if (mode_cmt == MODE_EDIT && timeout_hit) mode_next = return_mode_next;
    end

    // digit, timer and setpoint datapath
    always_comb begin
        digit_next       = digit_reg;
        idle_next        = idle_reg;
        volt_target_next = volt_target_reg;
        curr_target_next = curr_target_reg;
        volt_pend_next   = volt_pend_reg;
        curr_pend_next   = curr_pend_reg;
        timeout_hit      = 1'b0;

        if (in_mode_reg && mode_reg == MODE_EDIT) begin
            idle_next  = '0;
            digit_next = (digit_reg >= DIGIT_LAST) ? '0 : digit_reg + 3'd1;
        end

        if (in_commit_reg) begin
            if (mode_btn == MODE_EDIT) begin
                volt_target_next = volt_pend_reg;
                curr_target_next = curr_pend_reg;
            end else begin
                volt_pend_next = volt_target_reg;
                curr_pend_next = curr_target_reg;
                digit_next     = '0;
                idle_next      = '0;
            end
        end

        delta  = signed'(in_count_reg - signed'(last_count_reg));
        steps  = COUNT_W'(delta / DETENT_DIVISOR);
        weight = digit_weight(digit_next);
        change = SUM_W'(steps * signed'({1'b0, weight}));
        if (digit_next <= DIGIT_VOLT_LAST) begin
            base     = volt_pend_next;
            clamp_hi = voltage_max_reg;
            clamp_lo = voltage_min_reg;
        end else begin
            base     = {{(VOLT_W-CURR_W){1'b0}}, curr_pend_next};
            clamp_hi = {{(VOLT_W-CURR_W){1'b0}}, current_max_reg};
            clamp_lo = {{(VOLT_W-CURR_W){1'b0}}, current_min_reg};
        end
        sum     = change + signed'({{(SUM_W-VOLT_W){1'b0}}, base});
        clamped = clamp_value(sum, clamp_hi, clamp_lo);

        if (delta != '0 && mode_cmt == MODE_EDIT) begin
            idle_next = {{(TIMER_W-1){1'b0}}, idle_next[0]};
            if (digit_next <= DIGIT_VOLT_LAST) begin
                volt_pend_next = clamped;
            end else begin
                curr_pend_next = clamped[CURR_W-1:0];
            end
        end

        idle_inc = idle_next + 8'd1;
        if (mode_cmt == MODE_EDIT) begin
            idle_next = idle_inc;
            if (idle_inc >= edit_timeout_reg) begin
                timeout_hit = 1'b1;
                idle_next   = '0;
            end
        end

        out_data_next = {3'b000, idle_next, curr_pend_next, volt_pend_next,
                         curr_target_next, volt_target_next, digit_next, mode_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edit_timeout_reg <= TIMEOUT_RESET;
            voltage_max_reg  <= VOLT_MAX_RESET;
            voltage_min_reg  <= VOLT_MIN_RESET;
            current_max_reg  <= CURR_MAX_RESET;
            current_min_reg  <= CURR_MIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EDIT_TIMEOUT: edit_timeout_reg <= cfg_wdata[TIMER_W-1:0];
                CFG_VOLTAGE_MAX:  voltage_max_reg  <= cfg_wdata[VOLT_W-1:0];
                CFG_VOLTAGE_MIN:  voltage_min_reg  <= cfg_wdata[VOLT_W-1:0];
                CFG_CURRENT_MAX:  current_max_reg  <= cfg_wdata[CURR_W-1:0];
                CFG_CURRENT_MIN:  current_min_reg  <= cfg_wdata[CURR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_MAIN;
            return_mode_reg <= MODE_MAIN;
            digit_reg       <= '0;
            idle_reg        <= '0;
            volt_target_reg <= VOLT_TARGET_RESET;
            curr_target_reg <= CURR_TARGET_RESET;
            volt_pend_reg   <= '0;
            curr_pend_reg   <= '0;
            last_count_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire) begin
                mode_reg        <= mode_next;
                return_mode_reg <= return_mode_next;
                digit_reg       <= digit_next;
                idle_reg        <= idle_next;
                volt_target_reg <= volt_target_next;
                curr_target_reg <= curr_target_next;
                volt_pend_reg   <= volt_pend_next;
                curr_pend_reg   <= curr_pend_next;
                last_count_reg  <= in_count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_mode_reg   <= s_tdata[0];
            in_commit_reg <= s_tdata[1];
            in_count_reg  <= signed'(s_tdata[COUNT_W+1:2]);
        end
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    `FPSE_ASSERT_IMPL(a_digit_range, aclk, aresetn, 1'b1, digit_reg <= DIGIT_LAST)
    `FPSE_ASSERT_IMPL(a_return_not_edit, aclk, aresetn, 1'b1, return_mode_reg != MODE_EDIT)
    `FPSE_ASSERT_NEXT(a_result_loaded, aclk, aresetn, proc_fire, out_valid_reg)
    `FPSE_ASSERT_NEXT(a_state_holds, aclk, aresetn, !proc_fire,
        $stable({mode_reg, digit_reg, idle_reg, volt_pend_reg, curr_pend_reg}))

endmodule
